FILE: design/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg - shared types and constants for the FIR convolution filter
// Request layouts, opcodes, fixed-point widths and the control bundle that
// travels from the sequencer to the multiply-accumulate datapath.
// ----------------------------------------------------------------------------
package fcf_pkg;

    // Fixed-point format: Q1.15 samples and coefficients
    localparam int SAMPLE_W  = 16;
    localparam int FRAC_BITS = SAMPLE_W - 1;
    localparam int PROD_W    = 2 * SAMPLE_W;

    // Tap index and tap count register widths
    localparam int TAP_IDX_W = 10;
    localparam int TAP_CNT_W = 11;
    localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 11'd1024;

    // Accumulator holds up to 2^TAP_CNT_W full-scale products without wrap
    localparam int ACC_W = PROD_W + TAP_CNT_W;

    // Opcodes
    typedef logic [1:0] t_op;
    localparam t_op OP_TAP_WR    = 2'd0;
    localparam t_op OP_PUSH      = 2'd1;
    localparam t_op OP_PUSH_ZERO = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_samp;

    // Input request
    typedef struct packed {
        t_op                  op;
        logic [TAP_IDX_W-1:0] tap_index;
        t_samp                tap_value;
        t_samp                sample;
    } t_in_req;

    // Output request
    typedef struct packed {
        t_samp out_sample;
        logic  clipped;
    } t_out_req;

    // Per-term control from the sequencer to the MAC
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

FILE: design/fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// fir_convolution_filter - direct-form FIR convolution of an audio stream
// Input requests carry an opcode: write one tap coefficient, push a sample,
// or push a zero to drain the tail. Each push yields one output request
// with the Q1.15 sum of tap[k] * x[n-k], rounded, saturated and flagged.
//
// Usage:
//   Input channel : i_in_valid / o_in_stall / i_in_data (t_in_req).
//   Output channel: o_out_valid / i_out_stall / o_out_data (t_out_req).
//   Config        : i_cfg_we / i_cfg_data writes tap_count (1 .. MAX_TAPS
//                   taps used; 0 acts as 1). Write it only while the block
//                   is idle; the block itself does not enforce this.
//   A coefficient write gives no output. A push walks the N taps in use:
//   a coefficient and a delay line read per cycle feed one multiply-accumulate.
//   Pushes are processed one at a time; the next request is taken as soon
//   as the result sits in the output register, even if that is stalled.
//   If the output register is still full when a result is ready, the block
//   holds and stalls the input until the receiver takes it.
//   Reset clears the delay line history (through a fill count, at once),
//   the write position and sets tap_count to 1024. Coefficients are not
//   cleared and must be written before use.
// ----------------------------------------------------------------------------
module fir_convolution_filter #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fcf_pkg::TAP_CNT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fcf_pkg::t_in_req              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fcf_pkg::t_out_req             o_out_data
);
    import fcf_pkg::*;

    logic [TAP_CNT_W-1:0] r_tap_count;
    logic                 r_out_valid, n_out_valid;
    t_out_req             r_out_data;

    t_mac_ctl             mac_ctl;
    t_samp                mac_coef;
    t_samp                mac_samp;
    logic                 mac_done;
    t_out_req             mac_res;
    logic                 res_valid;
    logic                 res_take;

    // Tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_CNT_RESET;
        end else if (i_cfg_we) begin
            r_tap_count <= i_cfg_data;
        end
    end

    fcf_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_tap_count (r_tap_count),
        .o_ctl       (mac_ctl),
        .o_coef      (mac_coef),
        .o_samp      (mac_samp),
        .i_done      (mac_done),
        .o_res_valid (res_valid),
        .i_res_take  (res_take)
    );

    fcf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_coef  (mac_coef),
        .i_samp  (mac_samp),
        .o_done  (mac_done),
        .o_res   (mac_res)
    );

    // Output register: load when empty or being drained
    assign res_take    = res_valid && (!r_out_valid || !i_out_stall);
    assign n_out_valid = res_take || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= mac_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: design/fcf_mac.sv
// ----------------------------------------------------------------------------
// fcf_mac - multiply-accumulate datapath with rounding and saturation
// One product per cycle: a registered multiplier, then a wide accumulator.
// The final sum is rounded half up to Q1.15 and saturated.
// ----------------------------------------------------------------------------
module fcf_mac (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fcf_pkg::t_mac_ctl i_ctl,
    input  fcf_pkg::t_samp    i_coef,
    input  fcf_pkg::t_samp    i_samp,
    output logic              o_done,
    output fcf_pkg::t_out_req o_res
);
    import fcf_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2 ** (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] Q_MAX    = ACC_W'(2 ** FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] Q_MIN    = -Q_MAX - ACC_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_p_ctl;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  rnd_q;

    // Multiply stage
    assign n_prod   = i_coef * i_samp;
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_p_ctl.valid) begin
            r_acc <= r_p_ctl.first ? prod_ext : r_acc + prod_ext;
        end
    end

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
            r_done  <= 1'b0;
        end else begin
            r_p_ctl <= i_ctl;
            r_done  <= r_p_ctl.valid & r_p_ctl.last;
        end
    end

    // Round half up, floor shift, saturate
    assign rnd_sum = r_acc + RND_HALF;
    assign rnd_q   = rnd_sum >>> FRAC_BITS;

    always_comb begin
        if (rnd_q > Q_MAX) begin
            o_res.out_sample = Q_MAX[SAMPLE_W-1:0];
            o_res.clipped    = 1'b1;
        end else if (rnd_q < Q_MIN) begin
            o_res.out_sample = Q_MIN[SAMPLE_W-1:0];
            o_res.clipped    = 1'b1;
        end else begin
            o_res.out_sample = rnd_q[SAMPLE_W-1:0];
            o_res.clipped    = 1'b0;
        end
    end

    assign o_done = r_done;

endmodule

FILE: design/fcf_seq.sv
// ----------------------------------------------------------------------------
// fcf_seq - request sequencer with coefficient and delay line memories
// Takes one request at a time, writes the coefficient or the new sample,
// then, for a push, walks the taps, reading one coefficient and one sample per cycle.
// ----------------------------------------------------------------------------
module fcf_seq #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fcf_pkg::t_in_req               i_in_data,
    input  logic [fcf_pkg::TAP_CNT_W-1:0]  i_tap_count,
    output fcf_pkg::t_mac_ctl              o_ctl,
    output fcf_pkg::t_samp                 o_coef,
    output fcf_pkg::t_samp                 o_samp,
    input  logic                           i_done,
    output logic                           o_res_valid,
    input  logic                           i_res_take
);
    import fcf_pkg::*;

    localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW = $clog2(MAX_TAPS + 1);

    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_TAPS - 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(MAX_TAPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    // Memories
    t_samp r_coef_mem [MAX_TAPS];
    t_samp r_dly_mem  [MAX_TAPS];
    t_samp r_coef_q;
    t_samp r_dly_q;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_last, n_last;
    t_mac_ctl      r_rd_ctl, n_rd_ctl;
    logic          r_rd_mask;

    logic          in_acc;
    logic          is_push;
    logic          coef_we;
    logic [31:0]   tap_idx_ext;
    logic [31:0]   tc_ext;
    logic [31:0]   n_use;
    t_samp         push_val;

    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign is_push     = (i_in_data.op == OP_PUSH) || (i_in_data.op == OP_PUSH_ZERO);
    assign tap_idx_ext = 32'(i_in_data.tap_index);
    assign coef_we     = in_acc && (i_in_data.op == OP_TAP_WR)
                         && (tap_idx_ext < 32'(MAX_TAPS));
    assign push_val    = (i_in_data.op == OP_PUSH) ? i_in_data.sample : '0;

    // Taps in use, clamped to 1 .. MAX_TAPS
    assign tc_ext = 32'(i_tap_count);
    always_comb begin
        if (tc_ext == 32'd0) begin
            n_use = 32'd1;
        end else if (tc_ext > 32'(MAX_TAPS)) begin
            n_use = 32'(MAX_TAPS);
        end else begin
            n_use = tc_ext;
        end
    end

    // Next-state logic
    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_fill   = r_fill;
        n_k      = r_k;
        n_slot   = r_slot;
        n_last   = r_last;
        n_rd_ctl = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && is_push) begin
                    n_state = ST_RUN;
                    n_k     = '0;
                    n_slot  = r_head;
                    n_last  = AW'(n_use - 32'd1);
                    n_head  = (r_head == SLOT_LAST) ? '0 : r_head + AW'(1);
                    n_fill  = (r_fill == FILL_FULL) ? r_fill : r_fill + CW'(1);
                end
            end
            ST_RUN: begin
                n_rd_ctl.valid = 1'b1;
                n_rd_ctl.first = (r_k == '0);
                n_rd_ctl.last  = (r_k == r_last);
                if (r_k == r_last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_k    = r_k + AW'(1);
                    n_slot = (r_slot == '0) ? SLOT_LAST : r_slot - AW'(1);
                end
            end
            ST_WAIT: begin
                if (i_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_head   <= '0;
            r_fill   <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_fill   <= n_fill;
            r_rd_ctl <= n_rd_ctl;
        end
    end

    // Walk pointers and read-stage mask
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_slot    <= n_slot;
        r_last    <= n_last;
        r_rd_mask <= (CW'(r_k) < r_fill);
    end

    // Coefficient memory
    always_ff @(posedge i_clk) begin
        if (coef_we) begin
            r_coef_mem[tap_idx_ext[AW-1:0]] <= i_in_data.tap_value;
        end
        r_coef_q <= r_coef_mem[r_k];
    end

    // Delay line memory; slots never written since reset are masked to zero
    always_ff @(posedge i_clk) begin
        if (in_acc && is_push) begin
            r_dly_mem[r_head] <= push_val;
        end
        r_dly_q <= r_dly_mem[r_slot];
    end

    assign o_ctl       = r_rd_ctl;
    assign o_coef      = r_coef_q;
    assign o_samp      = r_rd_mask ? r_dly_q : '0;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);

endmodule
